// File: rtl/bcpe_pkg.sv
// Package for the Bezier curve point evaluator: widths, codes and shared types.
// Holds the fixed-point multiply and binomial table functions used by the datapath.
// Depends on nothing; every other file of the block imports it.
package bcpe_pkg;

  localparam int MAX_CTRL_PTS    = 8;
  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;

  localparam int STEP_W     = 16;
  localparam int SEG_W      = 16;
  localparam int NPTS_W     = 4;
  localparam int SLOT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Parameter u and the power products carry one integer bit so that 1.0 is exact.
  localparam int PW         = PARAM_FRAC_BITS + 1;
  localparam int DIVIDEND_W = STEP_W + PARAM_FRAC_BITS;
  localparam int NUM_POW    = MAX_CTRL_PTS - 1;
  localparam int BINOM_W    = MAX_CTRL_PTS;
  localparam int WGT_W      = BINOM_W + PW;
  localparam int PROD_W     = COORD_BITS + WGT_W + 1;
  localparam int ACC_W      = PROD_W + $clog2(MAX_CTRL_PTS);
  localparam int HALF       = (MAX_CTRL_PTS + 1) / 2;
  localparam int PIPE_LAT   = PW + NUM_POW + 4;

  localparam logic [NPTS_W-1:0] NPTS_RST = NPTS_W'(4);
  localparam logic [SEG_W-1:0]  SEG_RST  = SEG_W'(1000);
  localparam logic [PW-1:0]     ONE      = PW'(1) << PARAM_FRAC_BITS;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CTRL_PTS = 2'd0,
    CFG_NUM_SEGMENTS = 2'd1
  } cfg_idx_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [SLOT_W-1:0]  slot;
    coord_t [2:0]       pt;
  } item_t;

  // Product of two values with PARAM_FRAC_BITS fraction bits, rounded half up.
  function automatic logic [PW-1:0] qmul(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [2*PW-1:0] prod;
    prod = (2*PW)'(a) * (2*PW)'(b) + ((2*PW)'(1) << (PARAM_FRAC_BITS - 1));
    return prod[PARAM_FRAC_BITS +: PW];
  endfunction

  // Binomial coefficient from Pascal's triangle; only ever called with constants.
  function automatic logic [BINOM_W-1:0] binom(input int n, input int j);
    logic [BINOM_W-1:0] row [MAX_CTRL_PTS];
    for (int i = 0; i < MAX_CTRL_PTS; i++) row[i] = '0;
    row[0] = BINOM_W'(1);
    for (int r = 1; r <= n; r++) begin
      for (int i = r; i >= 1; i--) row[i] = row[i] + row[i-1];
    end
    return row[j];
  endfunction

endpackage

// File: rtl/bcpe_div.sv
// Pipelined restoring divider that forms the curve parameter u, one quotient bit per stage.
// Depends on bcpe_pkg.
module bcpe_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [bcpe_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [bcpe_pkg::SEG_W-1:0]       divisor_i,
  output logic                             valid_o,
  output logic [bcpe_pkg::PW-1:0]          quot_o
);
  import bcpe_pkg::*;

  logic              vld_q [PW];
  logic [SEG_W-1:0]  rem_q [PW];
  logic [SEG_W-1:0]  rem_d [PW];
  logic [PW-1:0]     low_q [PW];
  logic [PW-1:0]     low_d [PW];
  logic [PW-1:0]     quo_q [PW];
  logic [PW-1:0]     quo_d [PW];

  // Returns the quotient bit above the new remainder.
  function automatic logic [SEG_W:0] div_step(input logic [SEG_W-1:0] rem, input logic nb,
                                              input logic [SEG_W-1:0] d);
    logic [SEG_W:0] trial;
    trial = {rem, nb};
    if (trial >= {1'b0, d}) return {1'b1, SEG_W'(trial - {1'b0, d})};
    else return {1'b0, trial[SEG_W-1:0]};
  endfunction

  // The quotient is below 2^PW, so the upper dividend bits are already below the divisor.
  always_comb begin
    logic [SEG_W:0] st;
    st = div_step(SEG_W'(dividend_i[DIVIDEND_W-1:PW]), dividend_i[PW-1], divisor_i);
    rem_d[0] = st[SEG_W-1:0];
    quo_d[0] = {{(PW-1){1'b0}}, st[SEG_W]};
    low_d[0] = {dividend_i[PW-2:0], 1'b0};
    for (int s = 1; s < PW; s++) begin
      st = div_step(rem_q[s-1], low_q[s-1][PW-1], divisor_i);
      rem_d[s] = st[SEG_W-1:0];
      quo_d[s] = {quo_q[s-1][PW-2:0], st[SEG_W]};
      low_d[s] = {low_q[s-1][PW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PW; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < PW; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < PW; s++) begin
      rem_q[s] <= rem_d[s];
      low_q[s] <= low_d[s];
      quo_q[s] <= quo_d[s];
    end
  end

  assign valid_o = vld_q[PW-1];
  assign quot_o  = quo_q[PW-1];

endmodule

// File: rtl/bezier_curve_point_evaluator.sv
// Bezier curve point evaluator: fixed-point Bernstein blending of up to eight control points.
// An evaluate item passes the divider stages, the power stages and the weight, product,
// sum and final stage registers before valid_o rises with its result.
// Throughput: one item per cycle, set by the fully pipelined divider and power stages.
// busy stays low and the result side cannot stall, so nothing ever holds an item back.
// Reset clears the valid bits and sets num_ctrl_pts to 4 and num_segments to 1000;
// the control point store is not reset and must be loaded before it is read.
module bezier_curve_point_evaluator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cmd_i,
  input  logic [bcpe_pkg::SLOT_W-1:0]        point_index_i,
  input  logic signed [bcpe_pkg::COORD_BITS-1:0] ctrl_x_i,
  input  logic signed [bcpe_pkg::COORD_BITS-1:0] ctrl_y_i,
  input  logic signed [bcpe_pkg::COORD_BITS-1:0] ctrl_z_i,
  input  logic [bcpe_pkg::STEP_W-1:0]        step_index_i,
  output logic                               valid_o,
  output logic signed [bcpe_pkg::COORD_BITS-1:0] curve_x_o,
  output logic signed [bcpe_pkg::COORD_BITS-1:0] curve_y_o,
  output logic signed [bcpe_pkg::COORD_BITS-1:0] curve_z_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bcpe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bcpe_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bcpe_pkg::*;

  localparam logic signed [ACC_W-1:0] CMAX = ACC_W'((64'(1) << (COORD_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] CMIN = -CMAX - ACC_W'(1);

  // Configuration registers
  logic [NPTS_W-1:0] num_ctrl_pts_q;
  logic [SEG_W-1:0]  num_segments_q;
  logic [SEG_W-1:0]  seg;
  logic [NPTS_W-1:0] npts, n_deg;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ctrl_pts_q <= NPTS_RST;
      num_segments_q <= SEG_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NUM_CTRL_PTS: num_ctrl_pts_q <= cfg_data_i[NPTS_W-1:0];
        CFG_NUM_SEGMENTS: num_segments_q <= cfg_data_i[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    seg = (num_segments_q == '0) ? SEG_W'(1) : num_segments_q;
    if (num_ctrl_pts_q < NPTS_W'(2)) npts = NPTS_W'(2);
    else if (32'(num_ctrl_pts_q) > MAX_CTRL_PTS) npts = NPTS_W'(MAX_CTRL_PTS);
    else npts = num_ctrl_pts_q;
    n_deg = npts - NPTS_W'(1);
  end

  // Input: clamp the step and form the rounded dividend for u = k / seg.
  logic [STEP_W-1:0]     k_clamp;
  logic [DIVIDEND_W-1:0] dividend;
  item_t                 in_it;

  always_comb begin
    k_clamp  = (step_index_i > seg) ? seg : step_index_i;
    dividend = {k_clamp, {PARAM_FRAC_BITS{1'b0}}} + DIVIDEND_W'(seg >> 1);
    in_it.cmd   = cmd_e'(cmd_i);
    in_it.slot  = point_index_i;
    in_it.pt[0] = ctrl_x_i;
    in_it.pt[1] = ctrl_y_i;
    in_it.pt[2] = ctrl_z_i;
  end

  logic          div_vld;
  logic [PW-1:0] div_quot;
  item_t         dit_q [PW];

  bcpe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start),
    .dividend_i (dividend),
    .divisor_i  (seg),
    .valid_o    (div_vld),
    .quot_o     (div_quot)
  );

  // Item payload travels alongside the divider stages.
  always_ff @(posedge clk_i) begin
    dit_q[0] <= in_it;
    for (int s = 1; s < PW; s++) dit_q[s] <= dit_q[s-1];
  end

  // Power stages: stage s multiplies lane j by u while s < j, else by v, for s < n.
  logic          pin_v  [NUM_POW];
  item_t         pin_it [NUM_POW];
  logic [PW-1:0] pin_u  [NUM_POW];
  logic [PW-1:0] pin_c  [NUM_POW];
  logic [PW-1:0] pin_p  [NUM_POW][MAX_CTRL_PTS];
  logic [PW-1:0] pp_d   [NUM_POW][MAX_CTRL_PTS];
  logic          pv_q   [NUM_POW];
  item_t         pit_q  [NUM_POW];
  logic [PW-1:0] pu_q   [NUM_POW];
  logic [PW-1:0] pc_q   [NUM_POW];
  logic [PW-1:0] pp_q   [NUM_POW][MAX_CTRL_PTS];

  always_comb begin
    pin_v[0]  = div_vld;
    pin_it[0] = dit_q[PW-1];
    pin_u[0]  = div_quot;
    pin_c[0]  = ONE - div_quot;
    for (int j = 0; j < MAX_CTRL_PTS; j++) pin_p[0][j] = ONE;
    for (int s = 1; s < NUM_POW; s++) begin
      pin_v[s]  = pv_q[s-1];
      pin_it[s] = pit_q[s-1];
      pin_u[s]  = pu_q[s-1];
      pin_c[s]  = pc_q[s-1];
      pin_p[s]  = pp_q[s-1];
    end
    for (int s = 0; s < NUM_POW; s++) begin
      for (int j = 0; j < MAX_CTRL_PTS; j++) begin
        if (NPTS_W'(s) < n_deg) pp_d[s][j] = qmul(pin_p[s][j], (s < j) ? pin_u[s] : pin_c[s]);
        else pp_d[s][j] = pin_p[s][j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_POW; s++) pv_q[s] <= 1'b0;
    end else begin
      for (int s = 0; s < NUM_POW; s++) pv_q[s] <= pin_v[s];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NUM_POW; s++) begin
      pit_q[s] <= pin_it[s];
      pu_q[s]  <= pin_u[s];
      pc_q[s]  <= pin_c[s];
      pp_q[s]  <= pp_d[s];
    end
  end

  // Weight stage: binomial coefficient times power product.
  logic [BINOM_W-1:0] bc [MAX_CTRL_PTS];
  logic               wv_q;
  item_t              wit_q;
  logic [WGT_W-1:0]   w_q [MAX_CTRL_PTS];

  always_comb begin
    for (int j = 0; j < MAX_CTRL_PTS; j++) begin
      bc[j] = '0;
      for (int nn = 1; nn < MAX_CTRL_PTS; nn++) begin
        if (n_deg == NPTS_W'(nn)) bc[j] = binom(nn, j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wv_q <= 1'b0;
    else wv_q <= pv_q[NUM_POW-1];
  end

  always_ff @(posedge clk_i) begin
    wit_q <= pit_q[NUM_POW-1];
    for (int j = 0; j < MAX_CTRL_PTS; j++) begin
      w_q[j] <= WGT_W'(bc[j]) * WGT_W'(pp_q[NUM_POW-1][j]);
    end
  end

  // Product stage: loads update the store here, so evaluates see them in item order.
  coord_t [2:0]             cp_q [MAX_CTRL_PTS];
  logic                     xv_q;
  logic signed [PROD_W-1:0] prod_q [MAX_CTRL_PTS][3];

  always_ff @(posedge clk_i) begin
    if (wv_q && wit_q.cmd == CMD_LOAD && 32'(wit_q.slot) < MAX_CTRL_PTS) begin
      cp_q[wit_q.slot] <= wit_q.pt;
    end
    // Slots beyond the curve degree may never have been loaded, so they add nothing.
    for (int j = 0; j < MAX_CTRL_PTS; j++) begin
      for (int c = 0; c < 3; c++) begin
        if (NPTS_W'(j) <= n_deg) begin
          prod_q[j][c] <= PROD_W'(signed'(cp_q[j][c])) * PROD_W'(signed'({1'b0, w_q[j]}));
        end else begin
          prod_q[j][c] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) xv_q <= 1'b0;
    else xv_q <= wv_q && (wit_q.cmd == CMD_EVAL);
  end

  // Sum stage: two half sums per coordinate.
  logic                    av_q;
  logic signed [ACC_W-1:0] h_d [3][2];
  logic signed [ACC_W-1:0] h_q [3][2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      h_d[c][0] = '0;
      h_d[c][1] = '0;
      for (int j = 0; j < MAX_CTRL_PTS; j++) begin
        if (j < HALF) h_d[c][0] = h_d[c][0] + ACC_W'(prod_q[j][c]);
        else h_d[c][1] = h_d[c][1] + ACC_W'(prod_q[j][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) av_q <= 1'b0;
    else av_q <= xv_q;
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  // Final stage: round half up, drop the fraction, saturate.
  logic signed [ACC_W-1:0] acc [3];
  logic signed [ACC_W-1:0] rnd [3];
  coord_t                  res_d [3];
  coord_t                  res_q [3];
  logic                    valid_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = h_q[c][0] + h_q[c][1] + (ACC_W'(1) << (PARAM_FRAC_BITS - 1));
      rnd[c] = acc[c] >>> PARAM_FRAC_BITS;
      if (rnd[c] > CMAX) res_d[c] = COORD_BITS'(CMAX);
      else if (rnd[c] < CMIN) res_d[c] = COORD_BITS'(CMIN);
      else res_d[c] = COORD_BITS'(rnd[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= av_q;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o   = valid_q;
  assign curve_x_o = res_q[0];
  assign curve_y_o = res_q[1];
  assign curve_z_o = res_q[2];

endmodule

// File: rtl/bcpe_chk.sv
// Port-level checker for the Bezier curve point evaluator, bound to the top level.
// Depends on bcpe_pkg and bezier_curve_point_evaluator.
module bcpe_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               cmd_i,
  input logic [bcpe_pkg::STEP_W-1:0]        step_index_i,
  input logic                               valid_o,
  input logic signed [bcpe_pkg::COORD_BITS-1:0] curve_x_o,
  input logic signed [bcpe_pkg::COORD_BITS-1:0] curve_y_o,
  input logic signed [bcpe_pkg::COORD_BITS-1:0] curve_z_o
);
  import bcpe_pkg::*;

  // Every evaluate item yields its result after the fixed pipeline latency.
  a_eval_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i == CMD_EVAL |-> ##PIPE_LAT valid_o)
    else $error("evaluate item gave no result");

  // A load item never produces a result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i == CMD_LOAD |-> ##PIPE_LAT !valid_o)
    else $error("load item produced a result");

  // Two back-to-back evaluates of the same step give the same point.
  a_same_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(valid_o) &&
    $past(step_index_i, PIPE_LAT) == $past(step_index_i, PIPE_LAT + 1)
    |-> curve_x_o == $past(curve_x_o) && curve_y_o == $past(curve_y_o) &&
        curve_z_o == $past(curve_z_o))
    else $error("equal steps gave different points");

endmodule

bind bezier_curve_point_evaluator bcpe_chk u_bcpe_chk (.*);

// File: tb/bezier_curve_point_evaluator_tb.sv
// Self-checking testbench for bezier_curve_point_evaluator: loads control points,
// evaluates curve steps and compares every blended point with a built-in predictor.
// Depends on bcpe_pkg and the RTL of the evaluator only.
`timescale 1ns / 1ps

module bezier_curve_point_evaluator_tb;
  import bcpe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    cmd_e              cmd;
    logic [SLOT_W-1:0] slot;
    coord_t            x, y, z;
    logic [STEP_W-1:0] k;
  } bez_item_t;

  typedef struct {
    coord_t x, y, z;
  } curve_pt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_e cmd_i = CMD_LOAD;
  logic [SLOT_W-1:0] point_index_i = '0;
  coord_t ctrl_x_i = '0, ctrl_y_i = '0, ctrl_z_i = '0;
  logic [STEP_W-1:0] step_index_i = '0;
  logic valid_o;
  coord_t curve_x_o, curve_y_o, curve_z_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  bez_item_t pending_q[$];
  curve_pt_t curve_q[$];
  longint    ctrl_store[MAX_CTRL_PTS][3];
  logic [NPTS_W-1:0] npts_reg;
  logic [SEG_W-1:0]  seg_reg;
  int accepted_cnt = 0;
  int mismatch_cnt = 0;

  bezier_curve_point_evaluator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cmd_i(cmd_i), .point_index_i(point_index_i),
    .ctrl_x_i(ctrl_x_i), .ctrl_y_i(ctrl_y_i), .ctrl_z_i(ctrl_z_i),
    .step_index_i(step_index_i), .valid_o(valid_o),
    .curve_x_o(curve_x_o), .curve_y_o(curve_y_o), .curve_z_o(curve_z_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic coord_t round_sat(input longint acc);
    longint r;
    r = (acc + (64'sd1 <<< (PARAM_FRAC_BITS - 1))) >>> PARAM_FRAC_BITS;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return coord_t'(r);
  endfunction

  // Bernstein blend of the loaded points at step k under the current registers.
  function automatic curve_pt_t blend_curve_point(input logic [STEP_W-1:0] k_in);
    longint one, seg, k, u, v, p, c, w;
    longint acc[3];
    int npts, n;
    curve_pt_t pt;
    one = 64'sd1 <<< PARAM_FRAC_BITS;
    seg = (seg_reg == 0) ? 1 : seg_reg;
    k = k_in;
    if (k > seg) k = seg;
    u = ((k <<< PARAM_FRAC_BITS) + (seg >>> 1)) / seg;
    if (u > one) u = one;
    v = one - u;
    npts = npts_reg;
    if (npts < 2) npts = 2;
    if (npts > MAX_CTRL_PTS) npts = MAX_CTRL_PTS;
    n = npts - 1;
    for (int a = 0; a < 3; a++) acc[a] = 0;
    for (int j = 0; j < npts; j++) begin
      p = one;
      for (int i = 0; i < j; i++) p = (p * u + (one >>> 1)) >>> PARAM_FRAC_BITS;
      for (int i = j; i < n; i++) p = (p * v + (one >>> 1)) >>> PARAM_FRAC_BITS;
      c = 1;
      for (int i = 0; i < j; i++) c = c * (n - i) / (i + 1);
      w = c * p;
      for (int a = 0; a < 3; a++) acc[a] += ctrl_store[j][a] * w;
    end
    pt.x = round_sat(acc[0]);
    pt.y = round_sat(acc[1]);
    pt.z = round_sat(acc[2]);
    return pt;
  endfunction

  // Driver: predicts on acceptance, then presents the next item or idles.
  always @(posedge clk_i) begin
    bez_item_t nxt;
    logic      drive;
    drive = start;
    if (start && !busy) begin
      accepted_cnt++;
      if (cmd_i == CMD_LOAD) begin
        ctrl_store[point_index_i][0] = ctrl_x_i;
        ctrl_store[point_index_i][1] = ctrl_y_i;
        ctrl_store[point_index_i][2] = ctrl_z_i;
      end else begin
        curve_q.push_back(blend_curve_point(step_index_i));
      end
      drive = 1'b0;
      // Items 600 to 900 go through back to back.
      if (pending_q.size() != 0 &&
          ((accepted_cnt >= 600 && accepted_cnt < 900) || $urandom_range(99) >= 22)) begin
        nxt = pending_q.pop_front();
        cmd_i <= nxt.cmd;
        point_index_i <= nxt.slot;
        ctrl_x_i <= nxt.x;
        ctrl_y_i <= nxt.y;
        ctrl_z_i <= nxt.z;
        step_index_i <= nxt.k;
        drive = 1'b1;
      end
    end else if (!start && rst_ni && pending_q.size() != 0 && $urandom_range(99) >= 22) begin
      nxt = pending_q.pop_front();
      cmd_i <= nxt.cmd;
      point_index_i <= nxt.slot;
      ctrl_x_i <= nxt.x;
      ctrl_y_i <= nxt.y;
      ctrl_z_i <= nxt.z;
      step_index_i <= nxt.k;
      drive = 1'b1;
    end
    start <= drive;
  end

  // Monitor: every strobed point must match the oldest prediction.
  always @(posedge clk_i) begin
    curve_pt_t want;
    if (rst_ni && valid_o) begin
      if (curve_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected curve point %0d %0d %0d", curve_x_o, curve_y_o, curve_z_o);
      end else begin
        want = curve_q.pop_front();
        if (want.x !== curve_x_o || want.y !== curve_y_o || want.z !== curve_z_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("curve point mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     want.x, want.y, want.z, curve_x_o, curve_y_o, curve_z_o);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_NUM_CTRL_PTS) npts_reg = val[NPTS_W-1:0];
    else if (idx == CFG_NUM_SEGMENTS) seg_reg = val[SEG_W-1:0];
  endtask

  task automatic add_load(input int slot, input int x, input int y, input int z);
    bez_item_t it;
    it.cmd = CMD_LOAD;
    it.slot = SLOT_W'(slot);
    it.x = coord_t'(x);
    it.y = coord_t'(y);
    it.z = coord_t'(z);
    it.k = STEP_W'($urandom);
    pending_q.push_back(it);
  endtask

  task automatic add_eval(input int k);
    bez_item_t it;
    it.cmd = CMD_EVAL;
    it.slot = SLOT_W'($urandom);
    it.x = coord_t'($urandom);
    it.y = coord_t'($urandom);
    it.z = coord_t'($urandom);
    it.k = STEP_W'(k);
    pending_q.push_back(it);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return int'($urandom_range(64)) - 32;
      default: return int'(coord_t'($urandom));
    endcase
  endfunction

  task automatic drain();
    while (pending_q.size() != 0 || start || curve_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input int count);
    int lim;
    lim = (seg_reg == 0) ? 1 : seg_reg;
    repeat (count) begin
      if ($urandom_range(99) < 20) add_load($urandom_range(MAX_CTRL_PTS - 1),
                                            rand_coord(), rand_coord(), rand_coord());
      else case ($urandom_range(9))
        0: add_eval($urandom);
        1: add_eval($urandom_range(1) ? 0 : lim);
        default: add_eval($urandom_range(lim));
      endcase
    end
    drain();
  endtask

  initial begin
    int ext[4];
    ext = '{32767, -32768, 0, -1};
    npts_reg = NPTS_RST;
    seg_reg = SEG_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill every slot first so no evaluate reads an unwritten point.
    for (int s = 0; s < MAX_CTRL_PTS; s++)
      add_load(s, ext[s % 4], ext[(s + 1) % 4], ext[(s + 2) % 4]);
    add_eval(0);
    add_eval(1);
    add_eval(500);
    add_eval(999);
    add_eval(1000);
    add_eval(1001);
    add_eval(65535);
    for (int s = 0; s < MAX_CTRL_PTS; s++) add_load(s, 32767, -32768, 32767);
    add_eval(333);
    add_eval(65535);
    drain();

    write_reg(CFG_NUM_CTRL_PTS, 2);
    write_reg(CFG_NUM_SEGMENTS, 1);
    add_eval(0);
    add_eval(1);
    add_eval(2);
    random_phase(200);

    write_reg(CFG_NUM_CTRL_PTS, MAX_CTRL_PTS);
    write_reg(CFG_NUM_SEGMENTS, 16'hFFFF);
    add_eval(16'hFFFF);
    add_eval(16'h7FFF);
    random_phase(250);

    // Zero and oversize settings fall back to the nearest legal value.
    write_reg(CFG_NUM_CTRL_PTS, 0);
    write_reg(CFG_NUM_SEGMENTS, 0);
    random_phase(200);

    write_reg(CFG_NUM_CTRL_PTS, 16'hFFFF);
    write_reg(CFG_NUM_SEGMENTS, 7);
    random_phase(250);

    write_reg(CFG_NUM_CTRL_PTS, 1);
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    write_reg(CFG_SPARE_IDX, 16'h0001);
    random_phase(200);

    write_reg(CFG_NUM_CTRL_PTS, 3);
    write_reg(CFG_NUM_SEGMENTS, 16'h8000);
    random_phase(250);

    repeat (3) begin
      write_reg(CFG_NUM_CTRL_PTS, CFG_DATA_W'($urandom_range(2, MAX_CTRL_PTS)));
      write_reg(CFG_NUM_SEGMENTS, CFG_DATA_W'($urandom_range(1, 3000)));
      random_phase(180);
    end

    if (mismatch_cnt == 0 && curve_q.size() == 0) begin
      $display("bezier_curve_point_evaluator regression: pass");
    end else begin
      $display("bezier_curve_point_evaluator regression: fail");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("bezier_curve_point_evaluator regression: fail");
    $finish;
  end

endmodule

// File: bezier_curve_point_evaluator.f
rtl/bcpe_pkg.sv
rtl/bcpe_div.sv
rtl/bezier_curve_point_evaluator.sv
rtl/bcpe_chk.sv
tb/bezier_curve_point_evaluator_tb.sv
